// ===== src/c8ie_pkg.sv =====
// c8ie_pkg: shared widths, opcode codes and defaults for the chip8 instruction execute block
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
package c8ie_pkg;

  // field widths
  localparam int OP_W   = 4;
  localparam int ARG_W  = 12;
  localparam int PC_W   = 12;
  localparam int REG_W  = 8;
  localparam int RIDX_W = 4;
  localparam int NREGS  = 16;

  // default return stack depth
  localparam int STACK_DEPTH_DEF = 16;

  // program counter after reset and fetch step
  localparam logic [PC_W-1:0] PC_RESET = 12'h200;
  localparam logic [PC_W-1:0] PC_STEP  = 12'h002;

  // flag register index
  localparam logic [RIDX_W-1:0] FLAG_REG = 4'hF;

  // instruction classes (top nibble)
  localparam logic [OP_W-1:0] OP_SYS  = 4'h0;
  localparam logic [OP_W-1:0] OP_JP   = 4'h1;
  localparam logic [OP_W-1:0] OP_CALL = 4'h2;
  localparam logic [OP_W-1:0] OP_SE   = 4'h3;
  localparam logic [OP_W-1:0] OP_SNE  = 4'h4;
  localparam logic [OP_W-1:0] OP_SER  = 4'h5;
  localparam logic [OP_W-1:0] OP_LD   = 4'h6;
  localparam logic [OP_W-1:0] OP_ADD  = 4'h7;
  localparam logic [OP_W-1:0] OP_ALU  = 4'h8;

  // system words under class 0
  localparam logic [ARG_W-1:0] ARG_CLS = 12'h0E0;
  localparam logic [ARG_W-1:0] ARG_RET = 12'h0EE;

  // alu sub-operations (low nibble of class 8)
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;

  // subop zero for register compare
  localparam logic [3:0] SUB_NONE = 4'h0;

endpackage

// ===== src/c8ie_if.sv =====
// c8ie_if: valid/ready channels for instruction requests and execution results
// depends on c8ie_pkg for field widths
`timescale 1ns / 1ps

// instruction request channel
interface c8ie_in_if import c8ie_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ARG_W-1:0]  operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

// execution result channel
interface c8ie_out_if import c8ie_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PC_W-1:0]   next_pc;
  logic              reg_write;
  logic [RIDX_W-1:0] reg_index;
  logic [REG_W-1:0]  reg_value;
  logic              flag_write;
  logic              flag_value;
  logic              clear_screen;
  logic              unsupported;
  logic              stack_fault;

  modport source (output valid, output next_pc, output reg_write, output reg_index,
                  output reg_value, output flag_write, output flag_value,
                  output clear_screen, output unsupported, output stack_fault,
                  input ready);
  modport sink   (input valid, input next_pc, input reg_write, input reg_index,
                  input reg_value, input flag_write, input flag_value,
                  input clear_screen, input unsupported, input stack_fault,
                  output ready);
endinterface

// ===== src/chip8_instruction_execute.sv =====
// chip8_instruction_execute: executes one instruction word per request
// depends on c8ie_pkg and the channel interfaces in c8ie_if.sv
//
// Usage:
//   instr  : request channel carrying the top nibble (opcode) and low twelve
//            bits (operand) of one instruction word.
//   result : one result per request: next program counter, register and flag
//            writes, clear-screen pulse, unsupported and stack fault flags.
//   A request is decoded and executed against the register file, the program
//   counter and the return stack in the cycle it is taken; state updates at
//   that edge and the result lands in the output register.
//   The result is valid in the cycle after the request is taken.
//   Throughput: one request per cycle while results are taken; the next request
//   may use registers written by the previous one with no bubble.
//   The output register is freed in the same cycle it is drained, so instr
//   ready is high whenever the output register is empty or being taken.
//   When the receiver stalls, the result holds and instr ready drops until
//   the result is taken.
//   Reset clears the registers to zero, the stack level to zero and the pc
//   to 0x200; no clearing pass is needed and requests are taken right away.
//   Return stack: a memory with registered read that keeps the top entry in
//   a separate register, from which a return takes its target.
`timescale 1ns / 1ps
module chip8_instruction_execute import c8ie_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  c8ie_in_if.sink      instr,
  c8ie_out_if.source   result
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [LVL_W-1:0] LVL_DEPTH = LVL_W'(STACK_DEPTH);
  localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(1);
  localparam logic [LVL_W-1:0] LVL_TWO   = LVL_W'(2);

  // architectural state
  logic [REG_W-1:0] regs [NREGS];
  logic [PC_W-1:0]  pc;
  logic [LVL_W-1:0] level;
  logic [PC_W-1:0]  stack_mem [STACK_DEPTH];
  logic [PC_W-1:0]  stack_top;

  // output register
  logic              out_valid;
  logic [PC_W-1:0]   out_pc;
  logic              out_rw;
  logic [RIDX_W-1:0] out_ridx;
  logic [REG_W-1:0]  out_rval;
  logic              out_fw;
  logic              out_fv;
  logic              out_cls;
  logic              out_uns;
  logic              out_sf;

  // decode
  logic              accept;
  logic [RIDX_W-1:0] x;
  logic [RIDX_W-1:0] y;
  logic [REG_W-1:0]  kk;
  logic [3:0]        n;
  logic [REG_W-1:0]  vx;
  logic [REG_W-1:0]  vy;
  logic [REG_W-1:0]  gx;
  logic [REG_W-1:0]  gy;
  logic [REG_W:0]    sum;
  logic [PC_W-1:0]   pc_adv;
  logic [PC_W-1:0]   pc_skip;
  logic [LVL_W-1:0]  pop_slot;

  // execution results
  logic [PC_W-1:0]   pc_next;
  logic              rw;
  logic [REG_W-1:0]  rv;
  logic              fw;
  logic              fv;
  logic              cls;
  logic              uns;
  logic              sf;
  logic              push;
  logic              pop;

  // handshake
  assign instr.ready = !out_valid || result.ready;
  assign accept      = instr.valid && instr.ready;

  // field split and register reads
  assign x       = instr.operand[11:8];
  assign y       = instr.operand[7:4];
  assign kk      = instr.operand[7:0];
  assign n       = instr.operand[3:0];
  assign vx      = regs[x];
  assign vy      = regs[y];
  assign sum     = {1'b0, vx} + {1'b0, vy};
  assign pc_adv  = pc + PC_STEP;
  assign pc_skip = pc_adv + PC_STEP;

  // stack slot that becomes the new top after a return
  assign pop_slot = level - LVL_TWO;

  // register reads after the flag write
  assign gx = (x == FLAG_REG) ? REG_W'(fv) : vx;
  assign gy = (y == FLAG_REG) ? REG_W'(fv) : vy;

  // flag computation for alu class
  always_comb begin
    fw = 1'b0;
    fv = 1'b0;
    if (instr.opcode == OP_ALU) begin
      case (n)
        ALU_ADD: begin
          fw = 1'b1;
          fv = sum[REG_W];
        end
        ALU_SUB: begin
          fw = 1'b1;
          fv = vx > vy;
        end
        ALU_SHR: begin
          fw = 1'b1;
          fv = vx[0];
        end
        ALU_SUBN: begin
          fw = 1'b1;
          fv = vy > vx;
        end
        default: begin
          fw = 1'b0;
          fv = 1'b0;
        end
      endcase
    end
  end

  // instruction execute
  always_comb begin
    pc_next = pc_adv;
    rw      = 1'b0;
    rv      = '0;
    cls     = 1'b0;
    uns     = 1'b0;
    sf      = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    case (instr.opcode)
      OP_SYS: begin
        if (instr.operand == ARG_CLS) begin
          cls = 1'b1;
        end else if (instr.operand == ARG_RET) begin
          if (level == '0 || level > LVL_DEPTH) begin
            sf = 1'b1;
          end else begin
            pop     = 1'b1;
            pc_next = stack_top;
          end
        end else begin
          uns = 1'b1;
        end
      end
      OP_JP: begin
        pc_next = instr.operand;
      end
      OP_CALL: begin
        if (level >= LVL_DEPTH) begin
          sf = 1'b1;
        end else begin
          push    = 1'b1;
          pc_next = instr.operand;
        end
      end
      OP_SE: begin
        if (vx == kk) pc_next = pc_skip;
      end
      OP_SNE: begin
        if (vx != kk) pc_next = pc_skip;
      end
      OP_SER: begin
        if (n != SUB_NONE) begin
          uns = 1'b1;
        end else if (vx == vy) begin
          pc_next = pc_skip;
        end
      end
      OP_LD: begin
        rw = 1'b1;
        rv = kk;
      end
      OP_ADD: begin
        rw = 1'b1;
        rv = vx + kk;
      end
      OP_ALU: begin
        rw = 1'b1;
        case (n)
          ALU_MOV:  rv = vy;
          ALU_OR:   rv = vx | vy;
          ALU_AND:  rv = vx & vy;
          ALU_XOR:  rv = vx ^ vy;
          ALU_ADD:  rv = sum[REG_W-1:0];
          ALU_SUB:  rv = gx - gy;
          ALU_SHR:  rv = gx >> 1;
          ALU_SUBN: rv = gy - gx;
          default: begin
            rw  = 1'b0;
            uns = 1'b1;
          end
        endcase
      end
      default: begin
        uns = 1'b1;
      end
    endcase
  end

  // register file, pc and stack level
  // a result written to VF replaces the flag
  always_ff @(posedge clk) begin
    if (rst) begin
      regs  <= '{default: '0};
      pc    <= PC_RESET;
      level <= '0;
    end else if (accept) begin
      if (fw && (!rw || x != FLAG_REG)) regs[FLAG_REG] <= REG_W'(fv);
      if (rw) regs[x] <= rv;
      pc <= pc_next;
      if (push) begin
        level <= level + LVL_ONE;
      end else if (pop) begin
        level <= level - LVL_ONE;
      end
    end
  end

  // return stack memory with registered top entry
  always_ff @(posedge clk) begin
    if (accept && push) begin
      stack_mem[level[IDX_W-1:0]] <= pc_adv;
      stack_top <= pc_adv;
    end else if (accept && pop) begin
      stack_top <= stack_mem[pop_slot[IDX_W-1:0]];
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_pc   <= pc_next;
      out_rw   <= rw;
      out_ridx <= rw ? x : '0;
      out_rval <= rw ? rv : '0;
      out_fw   <= fw;
      out_fv   <= fv;
      out_cls  <= cls;
      out_uns  <= uns;
      out_sf   <= sf;
    end
  end

  assign result.valid        = out_valid;
  assign result.next_pc      = out_pc;
  assign result.reg_write    = out_rw;
  assign result.reg_index    = out_ridx;
  assign result.reg_value    = out_rval;
  assign result.flag_write   = out_fw;
  assign result.flag_value   = out_fv;
  assign result.clear_screen = out_cls;
  assign result.unsupported  = out_uns;
  assign result.stack_fault  = out_sf;

endmodule

// ===== tb/sv/chip8_instruction_execute_tb.sv =====
// chip8_instruction_execute_tb: self-checking bench for the chip8 instruction execute block
// depends on c8ie_pkg, the channel interfaces in c8ie_if.sv and chip8_instruction_execute
// a behavioral model predicts every result; random idling and stalls on both channels
`timescale 1ns / 1ps
module chip8_instruction_execute_tb;
  import c8ie_pkg::*;

  localparam int RET_DEPTH     = STACK_DEPTH_DEF;
  localparam int RET_IDX_W     = $clog2(RET_DEPTH);
  localparam int HOLD_CYCLES   = 48;
  localparam int SETTLE_CYCLES = 4;

  // codes the block does not implement
  localparam logic [OP_W-1:0] OP_SNE_REG  = 4'h9;
  localparam logic [OP_W-1:0] OP_MISC     = 4'hF;
  localparam logic [3:0]      ALU_UNUSED8 = 4'h8;
  localparam logic [3:0]      NIB_BAD     = 4'hF;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              reg_write;
    logic [RIDX_W-1:0] reg_index;
    logic [REG_W-1:0]  reg_value;
    logic              flag_write;
    logic              flag_value;
    logic              clear_screen;
    logic              unsupported;
    logic              stack_fault;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst;

  c8ie_in_if  instr_ch ();
  c8ie_out_if result_ch ();

  chip8_instruction_execute #(.STACK_DEPTH(RET_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // interpreter state as the bench sees it
  logic [REG_W-1:0] vreg [NREGS];
  logic [PC_W-1:0]  ret_stack [RET_DEPTH];
  int unsigned      call_depth;
  logic [PC_W-1:0]  pc_now;
  exec_result_t     expected_exec [$];

  int fail_count    = 0;
  bit src_gaps      = 1'b0;
  bit sink_stalls   = 1'b0;
  bit sink_hold_req = 1'b0;
  bit instr_offered = 1'b0;

  always #1 clk = ~clk;

  // execute one instruction word against the bench state
  function automatic exec_result_t run_instruction(input logic [15:0] word);
    exec_result_t      r;
    logic [OP_W-1:0]   op;
    logic [ARG_W-1:0]  arg;
    logic [RIDX_W-1:0] x;
    logic [RIDX_W-1:0] y;
    logic [3:0]        n;
    logic [REG_W-1:0]  kk;
    logic [REG_W-1:0]  vx;
    logic [REG_W-1:0]  vy;
    logic [REG_W-1:0]  rv;
    logic [REG_W:0]    sum;
    logic [PC_W-1:0]   pc;
    logic              wr;
    op  = word[15:12];
    arg = word[11:0];
    x   = arg[11:8];
    y   = arg[7:4];
    n   = arg[3:0];
    kk  = arg[7:0];
    vx  = vreg[x];
    vy  = vreg[y];
    pc  = pc_now + PC_STEP;
    r   = '0;
    wr  = 1'b0;
    rv  = '0;
    case (op)
      OP_SYS: begin
        if (arg == ARG_CLS) begin
          r.clear_screen = 1'b1;
        end else if (arg == ARG_RET) begin
          if (call_depth == 0) begin
            r.stack_fault = 1'b1;
          end else begin
            call_depth--;
            pc = ret_stack[call_depth[RET_IDX_W-1:0]];
          end
        end else begin
          r.unsupported = 1'b1;
        end
      end
      OP_JP: pc = arg;
      OP_CALL: begin
        if (call_depth >= RET_DEPTH) begin
          r.stack_fault = 1'b1;
        end else begin
          ret_stack[call_depth[RET_IDX_W-1:0]] = pc;
          call_depth++;
          pc = arg;
        end
      end
      OP_SE: if (vx == kk) pc = pc + PC_STEP;
      OP_SNE: if (vx != kk) pc = pc + PC_STEP;
      OP_SER: begin
        if (n != SUB_NONE) begin
          r.unsupported = 1'b1;
        end else if (vx == vy) begin
          pc = pc + PC_STEP;
        end
      end
      OP_LD: begin
        wr = 1'b1;
        rv = kk;
      end
      OP_ADD: begin
        wr = 1'b1;
        rv = vx + kk;
      end
      OP_ALU: begin
        wr = 1'b1;
        case (n)
          ALU_MOV: rv = vy;
          ALU_OR:  rv = vx | vy;
          ALU_AND: rv = vx & vy;
          ALU_XOR: rv = vx ^ vy;
          // sum uses the values read before the flag lands in VF
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            r.flag_write = 1'b1;
            r.flag_value = sum[REG_W];
            vreg[FLAG_REG] = REG_W'(r.flag_value);
            rv = sum[REG_W-1:0];
          end
          // the rest read the register file after the flag write
          ALU_SUB: begin
            r.flag_write = 1'b1;
            r.flag_value = (vx > vy);
            vreg[FLAG_REG] = REG_W'(r.flag_value);
            rv = vreg[x] - vreg[y];
          end
          ALU_SHR: begin
            r.flag_write = 1'b1;
            r.flag_value = vx[0];
            vreg[FLAG_REG] = REG_W'(r.flag_value);
            rv = vreg[x] >> 1;
          end
          ALU_SUBN: begin
            r.flag_write = 1'b1;
            r.flag_value = (vy > vx);
            vreg[FLAG_REG] = REG_W'(r.flag_value);
            rv = vreg[y] - vreg[x];
          end
          default: begin
            wr = 1'b0;
            r.unsupported = 1'b1;
          end
        endcase
      end
      default: r.unsupported = 1'b1;
    endcase
    if (wr) begin
      vreg[x]     = rv;
      r.reg_write = 1'b1;
      r.reg_index = x;
      r.reg_value = rv;
    end
    pc_now    = pc;
    r.next_pc = pc;
    return r;
  endfunction

  // random instruction word; without flow only data operations come out
  function automatic logic [15:0] random_instr(input bit flow);
    int               sel;
    logic [OP_W-1:0]  op;
    logic [ARG_W-1:0] arg;
    sel = flow ? $urandom_range(0, 99) : $urandom_range(0, 44);
    arg = ARG_W'($urandom);
    if (sel < 10) begin
      op = OP_LD;
    end else if (sel < 18) begin
      op = OP_ADD;
    end else if (sel < 45) begin
      op = OP_ALU;
      arg[3:0] = 4'($urandom_range(ALU_MOV, ALU_SUBN));
      if ($urandom_range(0, 7) == 0) arg[7:4] = arg[11:8];
    end else if (sel < 53) begin
      op = OP_SE;
      if ($urandom_range(0, 1) == 1) arg[7:0] = vreg[arg[11:8]];
    end else if (sel < 60) begin
      op = OP_SNE;
      if ($urandom_range(0, 1) == 1) arg[7:0] = vreg[arg[11:8]];
    end else if (sel < 68) begin
      op = OP_SER;
      if ($urandom_range(0, 3) != 0) arg[3:0] = SUB_NONE;
      if ($urandom_range(0, 1) == 1) arg[7:4] = arg[11:8];
    end else if (sel < 73) begin
      op = OP_JP;
    end else if (sel < 80) begin
      op = OP_CALL;
    end else if (sel < 87) begin
      op = OP_SYS;
      arg = ARG_RET;
    end else if (sel < 90) begin
      op = OP_SYS;
      arg = ARG_CLS;
    end else begin
      op = OP_W'($urandom);
    end
    return {op, arg};
  endfunction

  // offer one request and record its prediction once taken
  task automatic issue_instr(input logic [15:0] word);
    instr_ch.valid   <= 1'b1;
    instr_ch.opcode  <= word[15:12];
    instr_ch.operand <= word[11:0];
    instr_offered = 1'b1;
    do @(posedge clk); while (!instr_ch.ready);
    expected_exec.push_back(run_instruction(word));
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      instr_ch.valid <= 1'b0;
      instr_offered = 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop offering and let every predicted result come back
  task automatic wait_drained();
    if (instr_offered) begin
      instr_ch.valid <= 1'b0;
      instr_offered = 1'b0;
    end
    while (expected_exec.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    issue_instr({OP_SYS, ARG_CLS});
    issue_instr({OP_SYS, ARG_RET});               // return with empty stack
    issue_instr({OP_SYS, 12'hFFF});               // other system word
    issue_instr({OP_LD, 4'h0, 8'hFF});
    issue_instr({OP_LD, 4'hE, 8'h01});
    issue_instr({OP_ALU, 4'h0, 4'hE, ALU_ADD});   // carry out, sum wraps to zero
    issue_instr({OP_ADD, 4'h0, 8'hFF});
    issue_instr({OP_ADD, 4'h0, 8'h02});           // wraps, no flag
    issue_instr({OP_SE, 4'h0, 8'h01});            // skip taken
    issue_instr({OP_SNE, 4'h0, 8'h01});           // skip not taken
    issue_instr({OP_SER, 4'h0, 4'hE, SUB_NONE});  // equal registers skip
    issue_instr({OP_SER, 4'h0, 4'hE, NIB_BAD});   // bad low nibble
    issue_instr({OP_LD, 4'h2, 8'h05});
    issue_instr({OP_ALU, 4'h2, 4'hE, ALU_SUB});   // no borrow
    issue_instr({OP_ALU, 4'hE, 4'h2, ALU_SUBN});
    issue_instr({OP_ALU, 4'hF, 4'h2, ALU_SUB});   // result overwrites the flag
    issue_instr({OP_ALU, 4'h2, 4'h0, ALU_SHR});   // low bit shifted into flag
    issue_instr({OP_ALU, 4'hF, 4'hF, ALU_SUBN});  // flag register on both sides
    issue_instr({OP_ALU, 4'h1, 4'h0, ALU_OR});
    issue_instr({OP_ALU, 4'h1, 4'h2, ALU_AND});
    issue_instr({OP_ALU, 4'h1, 4'hE, ALU_XOR});
    issue_instr({OP_ALU, 4'h1, 4'h0, ALU_UNUSED8});
    issue_instr({OP_MISC, 12'hFFF});
    issue_instr({OP_JP, 12'hFFE});                // next fetch wraps the pc
    issue_instr({OP_CALL, 12'h300});              // pushes the wrapped pc
    issue_instr({OP_SYS, ARG_RET});
  endtask

  // nested calls past the stack limit, then returns past empty
  task automatic test_call_nesting();
    int levels;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    for (int round = 0; round < 6; round++) begin
      levels = (round == 0) ? RET_DEPTH + 2 : $urandom_range(1, RET_DEPTH + 2);
      repeat (levels) begin
        issue_instr({OP_CALL, ARG_W'($urandom)});
        if ($urandom_range(0, 2) == 0) issue_instr(random_instr(1'b0));
      end
      repeat (levels + 1) begin
        issue_instr({OP_SYS, ARG_RET});
        if ($urandom_range(0, 2) == 0) issue_instr(random_instr(1'b0));
      end
    end
  endtask

  // mixed traffic with quiet stretches and one full sender pause
  task automatic test_random_mix();
    for (int i = 0; i < 480; i++) begin
      src_gaps    = (i % 100) >= 15;
      sink_stalls = (i % 100) >= 15;
      if (i == 240) wait_drained();
      issue_instr(random_instr(1'b1));
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_result_backpressure();
    src_gaps      = 1'b0;
    sink_hold_req = 1'b1;
    repeat (40) issue_instr(random_instr(1'b1));
  endtask

  task automatic test_steady_stream();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (150) issue_instr(random_instr(1'b1));
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // result receiver: random stalls, long hold on request
  initial begin : result_sink
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    exec_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_exec.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected, next_pc %h", $time, result_ch.next_pc);
      end else begin
        want = expected_exec.pop_front();
        check_field("next_pc", 16'(want.next_pc), 16'(result_ch.next_pc));
        check_field("reg_write", 16'(want.reg_write), 16'(result_ch.reg_write));
        check_field("reg_index", 16'(want.reg_index), 16'(result_ch.reg_index));
        check_field("reg_value", 16'(want.reg_value), 16'(result_ch.reg_value));
        check_field("flag_write", 16'(want.flag_write), 16'(result_ch.flag_write));
        check_field("flag_value", 16'(want.flag_value), 16'(result_ch.flag_value));
        check_field("clear_screen", 16'(want.clear_screen),
                    16'(result_ch.clear_screen));
        check_field("unsupported", 16'(want.unsupported), 16'(result_ch.unsupported));
        check_field("stack_fault", 16'(want.stack_fault), 16'(result_ch.stack_fault));
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("chip8_instruction_execute regression: fail");
    $finish;
  end

  initial begin : main_seq
    rst              <= 1'b1;
    instr_ch.valid   <= 1'b0;
    instr_ch.opcode  <= '0;
    instr_ch.operand <= '0;
    vreg       = '{default: '0};
    call_depth = 0;
    pc_now     = PC_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_call_nesting();
    test_random_mix();
    test_result_backpressure();
    test_steady_stream();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_exec.size() == 0) begin
      $display("chip8_instruction_execute regression: pass");
    end else begin
      $display("chip8_instruction_execute regression: fail");
    end
    $finish;
  end

endmodule
